[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL. They compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FOPG_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fopg assertion failed");
`define FOPG_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fopg implication failed");
`else
`define FOPG_ASSERT(name, clk, rst, prop)
`define FOPG_ASSERT_IMP(name, clk, rst, ante, cons)
`endif
`endif

[rtl/core/fopg_pkg.sv]
// ----------------------------------------------------------------------------
// fopg_pkg
// Types and constants shared by the orbit point generator.
// ----------------------------------------------------------------------------
`default_nettype none
package fopg_pkg;

   localparam int unsigned CsrDataW  = 11;
   localparam int unsigned CsrIndexW = 2;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1,
      CSR_PIXEL_SCALE   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0] branch;
      logic       restart;
   } req_data_type;

   typedef struct packed {
      logic [9:0] pixel_x;
      logic [9:0] pixel_y;
      logic       visible;
   } rsp_data_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_SCALE,
      ST_SQRT,
      ST_MULD,
      ST_DIVS,
      ST_DIVGO,
      ST_DIVWAIT,
      ST_UPDATE,
      ST_PXMUL,
      ST_PYMUL,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MUL_AX,
      MUL_AY,
      MUL_RA,
      MUL_PX,
      MUL_PY
   } mul_sel_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        mul_en;
      logic        div_start;
      logic        busy;
   } ctrl_type;

endpackage
`default_nettype wire

[rtl/core/fopg_divider.sv]
// ----------------------------------------------------------------------------
// fopg_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module fopg_divider #(
   parameter int unsigned NUM_W = 56,
   parameter int unsigned DEN_W = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic                  done,
   output logic      [NUM_W-1:0] quotient
);
   localparam int unsigned CntW = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so it fits DEN_W bits.
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

[rtl/core/fractal_orbit_point_generator_core.sv]
// ----------------------------------------------------------------------------
// fractal_orbit_point_generator_core
// Random-iteration orbit generator: one fixed-point map step and one pixel
// per request transfer.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_stall, req_data) carries a branch
//   index, drawn at random upstream, and a restart flag. Each request
//   transfer moves the internal orbit point by one map step and produces
//   exactly one response transfer on rsp_valid / rsp_stall / rsp_data with
//   the pixel coordinate of the new point and a visible flag.
//   The csr_ port writes screen width, screen height and pixel scale; write
//   it only while no request is in flight.
//   The work runs as the 32-step square root and four divisions that share
//   one bit-serial divider, one quotient bit per cycle. req_stall is high for
//   the whole computation, so a new request is only taken once the previous
//   one has finished.
//   The result sits in an output register; a stalled receiver only delays
//   the next item if its result is still unclaimed when the next one ends.
//   Reset puts the orbit at the origin and the registers at 450, 450, 100.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module fractal_orbit_point_generator_core #(
   parameter int unsigned BRANCHES  = 3,
   parameter int unsigned FRAC_BITS = 24
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire fopg_pkg::req_data_type          req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output fopg_pkg::rsp_data_type               rsp_data,
   input  wire logic                            csr_write,
   input  wire logic [fopg_pkg::CsrIndexW-1:0]  csr_index,
   input  wire logic [fopg_pkg::CsrDataW-1:0]   csr_data
);
   import fopg_pkg::*;

   localparam int unsigned NumW  = 32 + FRAC_BITS;
   localparam int unsigned KW    = (BRANCHES > 2) ? $clog2(BRANCHES) : 1;
   localparam longint HalfPiQ30  = 64'sd1686629713;
   localparam longint OneQ30     = 64'sd1073741824;
   localparam longint TrigDiv    = 64'sd1 <<< (30 - FRAC_BITS);
   localparam longint SinDiv [7] = '{6, 20, 42, 72, 110, 156, 210};
   localparam longint CosDiv [7] = '{2, 12, 30, 56, 90, 132, 182};

   // Elaboration-time floor square root.
   function automatic longint unsigned isqrt_const(input longint unsigned v_in);
      longint unsigned v, res, b;
      v   = v_in;
      res = 0;
      b   = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + b) begin
            v   = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Elaboration-time branch constant: cosine or sine of 2*pi*k/BRANCHES.
   function automatic longint trig_const(input int k, input bit want_sin);
      int     quad, rem;
      longint a, a2, st, ct, ssum, csum, c, s;
      quad = (4 * k) / BRANCHES;
      rem  = (4 * k) % BRANCHES;
      a    = (longint'(rem) * HalfPiQ30) / BRANCHES;
      a2   = (a * a) / OneQ30;
      st   = a;
      ssum = a;
      ct   = OneQ30;
      csum = OneQ30;
      for (int n = 0; n < 7; n++) begin
         st   = -((st * a2) / OneQ30) / SinDiv[n];
         ct   = -((ct * a2) / OneQ30) / CosDiv[n];
         ssum = ssum + st;
         csum = csum + ct;
      end
      case (quad % 4)
         0:       begin c = csum;  s = ssum;  end
         1:       begin c = -ssum; s = csum;  end
         2:       begin c = -csum; s = -ssum; end
         default: begin c = ssum;  s = -csum; end
      endcase
      return want_sin ? (s / TrigDiv) : (c / TrigDiv);
   endfunction

   localparam longint unsigned RrSq =
      (longint'(5 * BRANCHES) << (2 * FRAC_BITS)) >> 2;
   localparam logic [31:0] Rr = 32'(isqrt_const(RrSq));

   // Maps a scaled coordinate to a pixel; bit 10 is the on-screen flag.
   function automatic logic [10:0] to_pixel(input logic [63:0] prod,
                                            input logic neg,
                                            input logic [10:0] size);
      logic signed [63:0] v;
      logic [63:0]        mag, q;
      logic               ok;
      v = neg ? -$signed(prod) : $signed(prod);
      v = v + $signed(64'(size >> 1) << FRAC_BITS);
      if (v < 0) begin
         // Truncation toward zero lands small negatives on column zero.
         mag = 64'(-v);
         q   = '0;
         ok  = (mag >> FRAC_BITS) == 64'd0 && size != 11'd0;
      end else begin
         q  = 64'(v) >> FRAC_BITS;
         ok = q < 64'(size) && q < 64'd1024;
      end
      return {ok, q[9:0]};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      return v[31] ? 32'(~v + 1'b1) : 32'(v);
   endfunction

   // Branch constant tables.
   logic signed [31:0] cos_tbl [BRANCHES];
   logic signed [31:0] sin_tbl [BRANCHES];
   for (genvar g = 0; g < BRANCHES; g++) begin : g_trig
      localparam logic signed [31:0] CosV = 32'(trig_const(g, 1'b0));
      localparam logic signed [31:0] SinV = 32'(trig_const(g, 1'b1));
      assign cos_tbl[g] = CosV;
      assign sin_tbl[g] = SinV;
   end

   // Configuration registers.
   logic [10:0] screen_width_ff, screen_height_ff;
   logic [9:0]  pixel_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= 11'd450;
         screen_height_ff <= 11'd450;
         pixel_scale_ff   <= 10'd100;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_data;
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_data;
            CSR_PIXEL_SCALE:   pixel_scale_ff   <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   state_type state_ff, state_in;
   ctrl_type  ctrl;

   logic signed [31:0] orbit_x_ff, orbit_y_ff;
   logic [KW-1:0]      k_ff;
   logic [63:0]        prod_ff, sum_ff;
   logic [63:0]        sq_v_ff, sq_res_ff;
   logic [4:0]         sq_cnt_ff;
   logic [63:0]        d1_ff, d2_ff;
   logic [1:0]         div_idx_ff;
   logic               div_neg_ff, div_zero_ff;
   logic signed [63:0] acc_x_ff, acc_y_ff;
   logic [10:0]        pix_x_ff;
   logic               rsp_valid_ff;
   rsp_data_type       rsp_data_ff;

   logic        accept;
   logic        rsp_free;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [63:0] sq_sum, sq_bit, sq_trial;
   logic signed [31:0] div_num;
   logic [63:0]        div_den;
   logic [NumW-1:0]    div_quo;
   logic               div_done;
   logic signed [63:0] div_q;
   logic [10:0]        pix_y;
   logic [2:0]         branch_ext;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_SQX;
         ST_SQX:     state_in = ST_SQY;
         ST_SQY:     state_in = ST_SCALE;
         ST_SCALE:   state_in = ST_SQRT;
         ST_SQRT:    if (sq_cnt_ff == 5'd31) state_in = ST_MULD;
         ST_MULD:    state_in = ST_DIVS;
         ST_DIVS:    state_in = ST_DIVGO;
         ST_DIVGO:   state_in = ST_DIVWAIT;
         ST_DIVWAIT: if (div_done) state_in = (div_idx_ff == 2'd3) ? ST_UPDATE : ST_DIVGO;
         ST_UPDATE:  state_in = ST_PXMUL;
         ST_PXMUL:   state_in = ST_PYMUL;
         ST_PYMUL:   state_in = ST_CHECK;
         ST_CHECK:   state_in = ST_DONE;
         ST_DONE:    if (rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      ctrl.mul_sel   = MUL_AX;
      ctrl.mul_en    = 1'b0;
      ctrl.div_start = 1'b0;
      ctrl.busy      = 1'b1;
      unique case (state_ff)
         ST_IDLE:  ctrl.busy = 1'b0;
         ST_SQX:   begin ctrl.mul_sel = MUL_AX; ctrl.mul_en = 1'b1; end
         ST_SQY:   begin ctrl.mul_sel = MUL_AY; ctrl.mul_en = 1'b1; end
         ST_MULD:  begin ctrl.mul_sel = MUL_RA; ctrl.mul_en = 1'b1; end
         ST_DIVGO: ctrl.div_start = 1'b1;
         ST_PXMUL: begin ctrl.mul_sel = MUL_PX; ctrl.mul_en = 1'b1; end
         ST_PYMUL: begin ctrl.mul_sel = MUL_PY; ctrl.mul_en = 1'b1; end
         default:  ;
      endcase
   end

   assign req_stall = ctrl.busy;

   // The one shared multiplier.
   always_comb begin
      mul_a = abs32(orbit_x_ff);
      mul_b = abs32(orbit_x_ff);
      case (ctrl.mul_sel)
         MUL_AY:  begin mul_a = abs32(orbit_y_ff); mul_b = abs32(orbit_y_ff); end
         MUL_RA:  begin mul_a = sq_res_ff[31:0];   mul_b = Rr; end
         MUL_PX:  begin mul_a = abs32(orbit_x_ff); mul_b = {22'd0, pixel_scale_ff}; end
         MUL_PY:  begin mul_a = abs32(orbit_y_ff); mul_b = {22'd0, pixel_scale_ff}; end
         default: ;
      endcase
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   // Square root step and radius operand.
   always_comb begin
      sq_sum   = sum_ff + prod_ff;
      sq_bit   = 64'd1 << (7'd62 - {1'b0, sq_cnt_ff, 1'b0});
      sq_trial = sq_res_ff + sq_bit;
   end

   // Division operands: x, y, x, y over rr, ra*rr, ra+rr, rr.
   always_comb begin
      div_num = div_idx_ff[0] ? orbit_y_ff : orbit_x_ff;
      case (div_idx_ff)
         2'd1:    div_den = d1_ff;
         2'd2:    div_den = d2_ff;
         default: div_den = 64'(Rr);
      endcase
   end

   fopg_divider #(
      .NUM_W (NumW),
      .DEN_W (64)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend ({abs32(div_num), {FRAC_BITS{1'b0}}}),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      div_q = $signed({{(64 - NumW){1'b0}}, div_quo});
      if (div_zero_ff) div_q = '0;
      else if (div_neg_ff) div_q = -div_q;
   end

   assign pix_y      = to_pixel(prod_ff, orbit_y_ff[31], screen_height_ff);
   assign branch_ext = {1'b0, req_data.branch};

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         orbit_x_ff   <= '0;
         orbit_y_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && rsp_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (accept && req_data.restart) begin
            orbit_x_ff <= '0;
            orbit_y_ff <= '0;
         end else if (state_ff == ST_UPDATE) begin
            orbit_x_ff <= sat32(acc_x_ff + 64'(cos_tbl[k_ff]));
            orbit_y_ff <= sat32(acc_y_ff + 64'(sin_tbl[k_ff]));
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         // Branch codes at or above BRANCHES wrap; one subtraction suffices.
         k_ff <= (branch_ext >= 3'(BRANCHES)) ? KW'(branch_ext - 3'(BRANCHES))
                                              : KW'(branch_ext);
      end
      if (ctrl.mul_en) prod_ff <= mul_p;
      unique case (state_ff)
         ST_SQY: sum_ff <= prod_ff;
         ST_SCALE: begin
            sq_v_ff   <= (sq_sum > 64'h1555_5555_5555_5555) ? '1
                                                           : (sq_sum << 3) + (sq_sum << 2);
            sq_res_ff <= '0;
            sq_cnt_ff <= '0;
         end
         ST_SQRT: begin
            if (sq_v_ff >= sq_trial) begin
               sq_v_ff   <= sq_v_ff - sq_trial;
               sq_res_ff <= (sq_res_ff >> 1) + sq_bit;
            end else begin
               sq_res_ff <= sq_res_ff >> 1;
            end
            sq_cnt_ff <= sq_cnt_ff + 1'b1;
         end
         ST_DIVS: begin
            d1_ff      <= prod_ff >> FRAC_BITS;
            d2_ff      <= 64'(sq_res_ff[31:0]) + 64'(Rr);
            div_idx_ff <= '0;
            acc_x_ff   <= '0;
            acc_y_ff   <= '0;
         end
         ST_DIVGO: begin
            div_neg_ff  <= div_num[31];
            div_zero_ff <= div_den == 64'd0;
         end
         ST_DIVWAIT: if (div_done) begin
            case (div_idx_ff)
               2'd0:    acc_x_ff <= acc_x_ff - div_q;
               2'd1:    acc_x_ff <= acc_x_ff + div_q;
               default: acc_y_ff <= acc_y_ff - div_q;
            endcase
            div_idx_ff <= div_idx_ff + 1'b1;
         end
         ST_PYMUL: pix_x_ff <= to_pixel(prod_ff, orbit_x_ff[31], screen_width_ff);
         // The output register only loads once the previous result has left.
         ST_DONE: if (rsp_free) begin
            rsp_data_ff.visible <= pix_x_ff[10] && pix_y[10];
            rsp_data_ff.pixel_x <= (pix_x_ff[10] && pix_y[10]) ? pix_x_ff[9:0] : 10'd0;
            rsp_data_ff.pixel_y <= (pix_x_ff[10] && pix_y[10]) ? pix_y[9:0] : 10'd0;
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A request transfer always starts the sequence at the first square.
   `FOPG_ASSERT_IMP(a_accept_starts, clock, reset, accept, ##1 state_ff == ST_SQX)
   // The divider only finishes while the sequencer is waiting for it.
   `FOPG_ASSERT_IMP(a_div_done_wait, clock, reset, div_done, state_ff == ST_DIVWAIT)
   // A pending response only clears through a transfer.
   `FOPG_ASSERT_IMP(a_rsp_drop, clock, reset, $fell(rsp_valid_ff), $past(!rsp_stall))
endmodule
`default_nettype wire

[tb/fractal_orbit_point_generator_core_tb.sv]
// ----------------------------------------------------------------------------
// fractal_orbit_point_generator_core_tb
// Self-checking bench for the orbit point generator core.
// ----------------------------------------------------------------------------
// A table of directed requests is sent first: restarts on every branch,
// including the out-of-range branch index, and runs of steps away from the
// origin. Random requests follow over several screen and scale settings,
// including the extremes, a zero screen size and a zero scale. Every request
// is run through a local fixed-point model of the orbit map. Each response
// transfer is compared field by field with the oldest predicted pixel.
// Both sides insert random idle cycles. In one phase the receiver holds off
// for a long stretch so the core backs up into its request port.
// ----------------------------------------------------------------------------
module fractal_orbit_point_generator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fopg_pkg::*;

   localparam int unsigned NumBranches = 3;
   localparam int unsigned FracBits    = 24;
   localparam longint      OneQ        = longint'(1) << FracBits;
   localparam longint      OneQ30      = 64'sd1073741824;
   localparam longint      HalfPiQ30   = 64'sd1686629713;
   localparam int unsigned CycleLimit  = 1000000;
   localparam int unsigned DrainCycles = 400;
   localparam int unsigned HoldCycles  = 2500;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_data_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_data_type rsp_data;
   logic         csr_write = 1'b0;
   logic [CsrIndexW-1:0] csr_index = '0;
   logic [CsrDataW-1:0]  csr_data = '0;

   fractal_orbit_point_generator_core #(
      .BRANCHES  (NumBranches),
      .FRAC_BITS (FracBits)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Local copy of the orbit state and the screen settings.
   int                orbit_x_q;
   int                orbit_y_q;
   longint unsigned   scr_width;
   longint unsigned   scr_height;
   longint unsigned   pix_scale;
   longint unsigned   r_const;
   longint            branch_cos [NumBranches];
   longint            branch_sin [NumBranches];

   rsp_data_type      pixel_expect_q[$];
   int unsigned       fail_count;
   int unsigned       rsp_count;
   int unsigned       req_count;
   int unsigned       cycle_count;
   bit                idle_on;
   bit                hold_request;
   int unsigned       hold_left;
   int unsigned       rsp_wait_left;

   // Floor square root of a 64-bit value, one result bit per iteration.
   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bit_q;
      res = 0;
      bit_q = 64'h1 << 62;
      while (bit_q > v) bit_q >>= 2;
      while (bit_q != 0) begin
         if (v >= res + bit_q) begin
            v -= res + bit_q;
            res = (res >> 1) + bit_q;
         end else begin
            res >>= 1;
         end
         bit_q >>= 2;
      end
      return res;
   endfunction

   // The branch offsets are the cosine and sine of 2*pi*k/BRANCHES. The angle
   // is folded into one quadrant and a truncated Taylor series is summed in
   // Q2.30, then cut down to the orbit format.
   function automatic void build_branch_table();
      int unsigned quad;
      int unsigned rem;
      longint      a, a2, st, ct, ssum, csum, c, s, div;
      for (int k = 0; k < NumBranches; k++) begin
         quad = (4 * k) / NumBranches;
         rem  = (4 * k) % NumBranches;
         a    = (longint'(rem) * HalfPiQ30) / longint'(NumBranches);
         a2   = (a * a) / OneQ30;
         st = a; ssum = a; ct = OneQ30; csum = OneQ30;
         for (int n = 1; n <= 7; n++) begin
            st = -((st * a2) / OneQ30) / longint'((2 * n) * (2 * n + 1));
            ct = -((ct * a2) / OneQ30) / longint'((2 * n - 1) * (2 * n));
            ssum += st;
            csum += ct;
         end
         case (quad & 3)
            0: begin c = csum;  s = ssum;  end
            1: begin c = -ssum; s = csum;  end
            2: begin c = -csum; s = -ssum; end
            default: begin c = ssum; s = -csum; end
         endcase
         div = longint'(1) << (30 - FracBits);
         branch_cos[k] = c / div;
         branch_sin[k] = s / div;
      end
      r_const = floor_sqrt((64'd5 * NumBranches << (2 * FracBits)) >> 2);
   endfunction

   function automatic int clamp_s32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
   endfunction

   // Maps one orbit coordinate onto a screen axis; clears on_screen when the
   // pixel falls outside the axis or outside what the 10-bit field holds.
   function automatic logic [9:0] axis_pixel(int p, longint unsigned size,
                                             inout bit on_screen);
      longint v;
      longint q;
      v = longint'(p) * longint'(pix_scale) + longint'(size >> 1) * OneQ;
      q = v / OneQ;
      if (q >= 0 && q < longint'(size) && q < 1024) return q[9:0];
      on_screen = 1'b0;
      return '0;
   endfunction

   // One map step of the orbit; returns the pixel the core should emit.
   function automatic rsp_data_type orbit_step(req_data_type d);
      int unsigned     k;
      longint          x, y, q1, q2, q3, q4;
      longint unsigned ax, ay, s, ra, d1, d2;
      bit              on_screen;
      rsp_data_type    pix;
      k = d.branch % NumBranches;
      if (d.restart) begin
         orbit_x_q = 0;
         orbit_y_q = 0;
      end
      x = orbit_x_q;
      y = orbit_y_q;
      ax = longint'(x < 0 ? -x : x);
      ay = longint'(y < 0 ? -y : y);
      s = ax * ax + ay * ay;
      s = (s > 64'hFFFF_FFFF_FFFF_FFFF / 12) ? 64'hFFFF_FFFF_FFFF_FFFF : s * 12;
      ra = floor_sqrt(s);
      d1 = (ra * r_const) >> FracBits;
      d2 = ra + r_const;
      // A zero divisor only shows up at the origin, where the quotient is 0.
      q1 = (x * OneQ) / longint'(r_const);
      q2 = (d1 != 0) ? (y * OneQ) / longint'(d1) : 0;
      q3 = (d2 != 0) ? (x * OneQ) / longint'(d2) : 0;
      q4 = (y * OneQ) / longint'(r_const);
      orbit_x_q = clamp_s32(-q1 + q2 + branch_cos[k]);
      orbit_y_q = clamp_s32(-q3 - q4 + branch_sin[k]);
      on_screen = 1'b1;
      pix.pixel_x = axis_pixel(orbit_x_q, scr_width, on_screen);
      pix.pixel_y = axis_pixel(orbit_y_q, scr_height, on_screen);
      if (!on_screen) begin
         pix.pixel_x = '0;
         pix.pixel_y = '0;
      end
      pix.visible = on_screen;
      return pix;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // Offers one request, with an optional idle gap first, and waits for the
   // transfer. The valid line stays high across back-to-back requests.
   task automatic send_request(req_data_type d, bit has_pixel, rsp_data_type pixel);
      int unsigned gap;
      rsp_data_type predicted;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (req_stall);
      predicted = orbit_step(d);
      // A typed-in pixel still has to agree with the model of the map.
      if (has_pixel && predicted != pixel)
         report_mismatch("table row pixel", int'(predicted), int'(pixel));
      pixel_expect_q.push_back(predicted);
      req_count++;
   endtask

   task automatic send_random(int unsigned n);
      req_data_type d;
      for (int i = 0; i < n; i++) begin
         d.branch  = $urandom_range(0, 3);
         d.restart = ($urandom_range(0, 15) == 0);
         send_request(d, 1'b0, '0);
      end
   endtask

   // Waits until every predicted pixel has been seen, then lets the core
   // settle before the settings change.
   task automatic drain_and_idle();
      req_valid <= 1'b0;
      while (pixel_expect_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_screen(int unsigned w, int unsigned h, int unsigned sc);
      csr_write <= 1'b1;
      csr_index <= CSR_SCREEN_WIDTH;
      csr_data  <= w[CsrDataW-1:0];
      @(posedge clock);
      csr_index <= CSR_SCREEN_HEIGHT;
      csr_data  <= h[CsrDataW-1:0];
      @(posedge clock);
      csr_index <= CSR_PIXEL_SCALE;
      csr_data  <= sc[CsrDataW-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      scr_width  = w & 11'h7FF;
      scr_height = h & 11'h7FF;
      pix_scale  = sc & 10'h3FF;
   endtask

   typedef struct {
      logic [1:0]   branch;
      logic         restart;
      bit           has_pixel;
      rsp_data_type pixel;
   } table_row_type;

   // From the origin, branch 0 (and the out-of-range index 3, which wraps to
   // it) lands on (1, 0): 100 pixels right of the center of a 450-wide screen.
   localparam rsp_data_type CenterPlusOne = '{pixel_x: 10'd325, pixel_y: 10'd225,
                                              visible: 1'b1};
   table_row_type directed_rows [20] = '{
      '{2'd0, 1'b1, 1'b1, CenterPlusOne},
      '{2'd1, 1'b1, 1'b0, '0},
      '{2'd2, 1'b1, 1'b0, '0},
      '{2'd3, 1'b1, 1'b1, CenterPlusOne},
      '{2'd0, 1'b0, 1'b0, '0},
      '{2'd0, 1'b0, 1'b0, '0},
      '{2'd1, 1'b0, 1'b0, '0},
      '{2'd2, 1'b0, 1'b0, '0},
      '{2'd3, 1'b0, 1'b0, '0},
      '{2'd1, 1'b0, 1'b0, '0},
      '{2'd0, 1'b1, 1'b1, CenterPlusOne},
      '{2'd2, 1'b0, 1'b0, '0},
      '{2'd2, 1'b0, 1'b0, '0},
      '{2'd1, 1'b0, 1'b0, '0},
      '{2'd3, 1'b1, 1'b1, CenterPlusOne},
      '{2'd3, 1'b0, 1'b0, '0},
      '{2'd0, 1'b0, 1'b0, '0},
      '{2'd1, 1'b1, 1'b0, '0},
      '{2'd1, 1'b0, 1'b0, '0},
      '{2'd2, 1'b0, 1'b0, '0}
   };

   // Receiver: a random number of stall cycles after each response transfer,
   // or a long hold-off counted down here when the sender asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait_left = 0;
         hold_left = 0;
      end else begin
         if (hold_request) begin
            hold_left = HoldCycles;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (rsp_valid && !rsp_stall) begin
               rsp_wait_left = idle_on ? $urandom_range(0, 7) : 0;
            end else if (rsp_wait_left > 0) begin
               rsp_wait_left--;
            end
            rsp_stall <= (rsp_wait_left != 0);
         end
      end
   end

   // Checks each response transfer against the oldest predicted pixel.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_expect_q.size() == 0) begin
            $display("[%0t] response transfer with no request pending", $realtime);
            fail_count++;
         end else begin
            rsp_data_type want;
            want = pixel_expect_q.pop_front();
            if (rsp_data.pixel_x !== want.pixel_x)
               report_mismatch("pixel_x", rsp_data.pixel_x, want.pixel_x);
            if (rsp_data.pixel_y !== want.pixel_y)
               report_mismatch("pixel_y", rsp_data.pixel_y, want.pixel_y);
            if (rsp_data.visible !== want.visible)
               report_mismatch("visible", rsp_data.visible, want.visible);
            rsp_count++;
         end
      end
   end

   // Watchdog: a run that hangs ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pixel_expect_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      fail_count = 0;
      rsp_count = 0;
      req_count = 0;
      cycle_count = 0;
      idle_on = 1'b1;
      hold_request = 1'b0;
      orbit_x_q = 0;
      orbit_y_q = 0;
      scr_width = 450;
      scr_height = 450;
      pix_scale = 100;
      build_branch_table();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows run on the reset settings.
      foreach (directed_rows[i]) begin
         send_request('{branch: directed_rows[i].branch, restart: directed_rows[i].restart},
                      directed_rows[i].has_pixel, directed_rows[i].pixel);
      end
      send_random(230);
      // The sender pauses here until every pixel is back.
      drain_and_idle();

      write_screen(1024, 1024, 1023);
      send_random(140);
      drain_and_idle();

      // Screens wider than the pixel field can address.
      write_screen(2047, 2047, 300);
      send_random(100);
      drain_and_idle();

      write_screen(1, 1, 1);
      send_random(80);
      drain_and_idle();

      // Zero screen size: nothing is ever visible.
      write_screen(0, 0, 100);
      send_random(50);
      drain_and_idle();

      // Zero scale: every point maps to the screen center.
      write_screen(600, 300, 0);
      send_random(50);
      drain_and_idle();

      // The receiver holds off while requests keep coming, so the result
      // register fills and the core stalls its request port.
      write_screen(800, 700, 200);
      hold_request = 1'b1;
      send_random(20);
      // A stretch with no idle cycles on either side.
      idle_on = 1'b0;
      send_random(150);
      idle_on = 1'b1;
      send_random(110);
      drain_and_idle();

      $display("sent %0d requests and checked %0d pixels over seven screen settings",
               req_count, rsp_count);
      $display("settings covered extremes, zero size, zero scale and a long output stall");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
